FILE: rtl/ple_pkg.sv
// ---------------------------------------------------------------------------
// ple_pkg: shared types and constants for the positional list engine
// Field widths, operation codes and the command handed to each list cell.
// ---------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;

    // Operation codes carried in the request op field
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Broadcast to every cell in the row for one accepted transaction
    typedef struct packed {
        logic              ins;    // open a gap at the position
        logic              del;    // close the gap at the position
        logic [DATA_W-1:0] value;  // value written into the gap
    } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ple_req_if.sv
// ---------------------------------------------------------------------------
// ple_req_if: request channel of the positional list engine
// Valid/ready channel carrying one insert or delete request.
// ---------------------------------------------------------------------------
`default_nettype none

interface ple_req_if;
    import ple_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic signed [DATA_W-1:0] value;
    logic [LEN_W-1:0]         position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

`default_nettype wire

FILE: rtl/ple_rsp_if.sv
// ---------------------------------------------------------------------------
// ple_rsp_if: result channel of the positional list engine
// Valid/ready channel carrying the outcome of one request.
// ---------------------------------------------------------------------------
`default_nettype none

interface ple_rsp_if;
    import ple_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] removed_value;
    logic [LEN_W-1:0]         length;

    modport source (output valid, output ok, output removed_value, output length, input ready);
    modport sink   (input valid, input ok, input removed_value, input length, output ready);
endinterface

`default_nettype wire

FILE: rtl/ple_cell.sv
// ---------------------------------------------------------------------------
// ple_cell: one storage slot of the list
// Holds, takes the new value or its lower neighbour on insert, or its upper
// neighbour on delete, depending on its own index against the position.
// ---------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
    parameter int IDX   = 0,
    parameter int POS_W = 7
) (
    input  wire                        clk,
    input  ple_pkg::cell_cmd_t         cmd,
    input  wire [POS_W-1:0]            pos,
    input  wire [ple_pkg::DATA_W-1:0]  left,   // slot at index - 1
    input  wire [ple_pkg::DATA_W-1:0]  right,  // slot at index + 1
    output logic [ple_pkg::DATA_W-1:0] slot,
    output logic [ple_pkg::DATA_W-1:0] pick    // own slot when it is deleted
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [DATA_W-1:0] slot_reg;
    logic [DATA_W-1:0] slot_next;
    logic              at_pos;
    logic              above_pos;

    assign at_pos    = (pos == MY_IDX);
    assign above_pos = (MY_IDX > pos);

    // Next slot contents
    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.ins)
        begin
            if (above_pos)
                slot_next = left;
            else if (at_pos)
                slot_next = cmd.value;
        end
        else if (cmd.del)
        begin
            if (above_pos || at_pos)
                slot_next = right;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;
    assign pick = (cmd.del && at_pos) ? slot_reg : '0;

endmodule

`default_nettype wire

FILE: rtl/positional_list_engine.sv
// ---------------------------------------------------------------------------
// positional_list_engine: ordered list with insert and delete at an index
// A row of slot cells shifts up to open a gap or down to close one; the
// removed value is gathered from the cell at the position.
// ---------------------------------------------------------------------------
//  Channel | Direction | Carries
//  req     | in        | op, value, position
//  rsp     | out       | ok, removed_value, length
//
//  One request per clock unless rsp stalls: the whole row shifts in the cycle
//  a transaction is accepted and its result is registered for the next cycle.
//  A request is taken while the result register is empty or being drained,
//  so a stalled rsp holds req off after one pending result.
//  Reset empties the list (length 0); slot contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input wire       clk,
    input wire       rst_n,
    ple_req_if.sink  req,
    ple_rsp_if.source rsp
);
    import ple_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;

    logic                  rsp_valid_reg;
    logic                  rsp_ok_reg;
    logic [DATA_W-1:0]     rsp_removed_reg;
    logic [LEN_W-1:0]      rsp_length_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;

    logic                  accept;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      fill_ext;
    logic                  ins_ok;
    logic                  del_ok;
    cell_cmd_t             cmd;
    logic [DATA_W-1:0]     slot_q [CAPACITY];
    logic [DATA_W-1:0]     pick_q [CAPACITY];
    logic [DATA_W-1:0]     removed;

    // Handshake
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Range checks
    assign pos_ext  = CMP_W'(req.position);
    assign fill_ext = CMP_W'(fill_reg);
    assign ins_ok   = (req.op == OP_INSERT) && (pos_ext <= fill_ext)
                      && (fill_ext < CMP_W'(CAPACITY));
    assign del_ok   = (req.op == OP_DELETE) && (pos_ext < fill_ext);

    assign cmd.ins   = accept && ins_ok;
    assign cmd.del   = accept && del_ok;
    assign cmd.value = req.value;

    // Row of slot cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = req.value;
        end
        else
        begin : g_mid_lo
            assign left_d = slot_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = slot_q[i];
        end
        else
        begin : g_mid_hi
            assign right_d = slot_q[i+1];
        end

        ple_cell #(
            .IDX   (i),
            .POS_W (CMP_W)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .pos   (pos_ext),
            .left  (left_d),
            .right (right_d),
            .slot  (slot_q[i]),
            .pick  (pick_q[i])
        );
    end

    // Only the deleted cell drives a non-zero pick
    always_comb
    begin
        removed = '0;
        for (int k = 0; k < CAPACITY; k++)
            removed = removed | pick_q[k];
    end

    // Element count
    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.ins)
            fill_next = fill_reg + FILL_W'(1);
        else if (cmd.del)
            fill_next = fill_reg - FILL_W'(1);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_ok_reg      <= ins_ok || del_ok;
            rsp_removed_reg <= removed;
            rsp_length_reg  <= LEN_W'(fill_next);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = rsp_ok_reg;
    assign rsp.removed_value = rsp_removed_reg;
    assign rsp.length        = rsp_length_reg;

endmodule

`default_nettype wire
